[src/rlce_pkg.sv]
// Shared types and constants for the RGB lux / colour temperature estimator.
// Used by the channel interfaces and the top level; no dependencies.
package rlce_pkg;

  localparam int COUNT_W = 16;
  localparam int LUX_W   = 29;
  localparam int KELV_W  = 16;

  // Configuration register indexes
  typedef enum logic {
    REG_GAIN_CODE  = 1'b0,
    REG_INTEG_TIME = 1'b1
  } cfg_reg_e;

  localparam logic [12:0] INTEG_RESET   = 13'd24;
  localparam logic [12:0] INTEG_DEFAULT = 13'd10;

  localparam logic [LUX_W-1:0]  LUX_MAX  = {LUX_W{1'b1}};
  localparam logic [KELV_W-1:0] KELV_MAX = {KELV_W{1'b1}};

  // Chromaticity offsets 0.3320 and 0.1858 in Q0.16
  localparam logic signed [17:0] X_OFFSET = 18'sd21758;
  localparam logic signed [17:0] Y_OFFSET = 18'sd12177;

  // n saturates at 127.0 in Q7.16
  localparam logic [22:0] N_LIMIT = 23'd8323072;

  // Cubic coefficients in Q16, except C3, which is a plain integer
  localparam logic signed [33:0] C3_INT = 34'sd449;
  localparam logic signed [33:0] C2_Q16 = 34'sd231014400;
  localparam logic signed [40:0] C1_Q16 = 41'sd447171789;
  localparam logic signed [48:0] C0_Q16 = 49'sd361780347;

  function automatic logic [5:0] gain_mult(input logic [1:0] code);
    logic [5:0] m;
    unique case (code)
      2'd0: m = 6'd1;
      2'd1: m = 6'd4;
      2'd2: m = 6'd16;
      2'd3: m = 6'd60;
      default: m = 6'd1;
    endcase
    return m;
  endfunction

endpackage

[src/rlce_if.sv]
// Valid/ready channel interfaces for the estimator's input and result streams.
// Depends on rlce_pkg for field widths.
interface rlce_in_if import rlce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] red_count;
  logic [COUNT_W-1:0] green_count;
  logic [COUNT_W-1:0] blue_count;

  modport source (output valid, red_count, green_count, blue_count, input ready);
  modport sink   (input valid, red_count, green_count, blue_count, output ready);
endinterface

interface rlce_out_if import rlce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LUX_W-1:0]  lux_sixteenths;
  logic [KELV_W-1:0] cct_kelvin;
  logic              cct_saturated;

  modport source (output valid, lux_sixteenths, cct_kelvin, cct_saturated, input ready);
  modport sink   (input valid, lux_sixteenths, cct_kelvin, cct_saturated, output ready);
endinterface

[src/rgb_lux_and_cct_estimator.sv]
// Top level of the RGB lux and colour temperature estimator.
// Depends on rlce_pkg, rlce_if and rlce_div_chain.
//
// Usage:
//   in_i carries one red/green/blue count triple per transfer; out_o returns
//   one result per triple, in order: lux in 1/16 lux, temperature in kelvin
//   and a saturation flag. Both channels transfer when valid and ready are
//   high at a rising clock edge.
//   cfg_we_i/cfg_index_i/cfg_data_i write gain_code (index 0) or
//   integration_tenth_ms (index 1); write them only while the block is idle.
//   From input transfer to output valid, an item passes the input stage,
//   which loads at the transfer edge, then a 34-cell lux divider, a 17-cell
//   chromaticity divider, one stage, a 23-cell divider for n, six cubic
//   stages and the output register.
//   Throughput is one triple per cycle while the output is not stalled; every
//   divider cell works on a different item.
//   When the receiver stalls, the pipeline keeps moving until an item reaches
//   the stage behind the output register, then it holds and in_i.ready drops.
//   Reset empties the pipeline and sets gain x1 and 2.4 ms integration.
module rgb_lux_and_cct_estimator import rlce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  rlce_in_if.sink     in_i,
  rlce_out_if.source  out_o
);

  // ---------------- configuration ----------------
  logic [1:0]  gain_q;
  logic [12:0] integ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 2'd0;
      integ_q <= INTEG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GAIN_CODE:  gain_q  <= cfg_data_i[1:0];
        REG_INTEG_TIME: integ_q <= cfg_data_i;
        default:        gain_q  <= gain_q;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic out_valid_q, i_valid_q;
  logic out_load, en;

  assign out_load   = !out_valid_q || out_o.ready;
  assign en         = out_load || !i_valid_q;
  assign in_i.ready = en;

  // ---------------- stage A: weighted sums ----------------
  logic [26:0] lux_pos_w;
  logic [24:0] lux_neg_w;
  logic [26:0] lux_diff_w;
  logic [12:0] tenths_w;
  logic [31:0] x_w, y_w, z_w;

  assign lux_pos_w  = 27'(in_i.red_count) * 27'd136 + 27'(in_i.green_count) * 27'd1000;
  assign lux_neg_w  = 25'(in_i.blue_count) * 25'd444;
  assign lux_diff_w = lux_pos_w - 27'(lux_neg_w);
  assign tenths_w   = (integ_q == 13'd0) ? INTEG_DEFAULT : integ_q;

  assign x_w = 32'(in_i.red_count) * 32'd27688 + 32'(in_i.green_count) * 32'd17517
             + 32'(in_i.blue_count) * 32'd11301;
  assign y_w = 32'(in_i.red_count) * 32'd10000 + 32'(in_i.green_count) * 32'd45906
             + 32'(in_i.blue_count) * 32'd601;
  assign z_w = 32'(in_i.green_count) * 32'd565 + 32'(in_i.blue_count) * 32'd55942;

  logic        a_valid_q, a_pos_q;
  logic [33:0] a_num_q;
  logic [18:0] a_den_q;
  logic [31:0] a_x_q, a_y_q;
  logic [33:0] a_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pos_q <= lux_pos_w > 27'(lux_neg_w);
      // times 160 = times 128 plus times 32
      a_num_q <= {lux_diff_w, 7'd0} + {2'b00, lux_diff_w, 5'd0};
      a_den_q <= 19'(gain_mult(gain_q)) * 19'(tenths_w);
      a_x_q   <= x_w;
      a_y_q   <= y_w;
      a_s_q   <= 34'(x_w) + 34'(y_w) + 34'(z_w);
    end
  end

  // ---------------- lux divider ----------------
  localparam int LSW = 1 + 32 + 32 + 34;

  logic                  l_valid;
  logic [0:0][18:0]      l_rem;
  logic [0:0][33:0]      l_bits, l_quot;
  logic [LSW-1:0]        l_side_in, l_side;

  assign l_rem[0]  = '0;
  assign l_bits[0] = a_num_q;
  assign l_side_in = {a_pos_q, a_x_q, a_y_q, a_s_q};

  rlce_div_chain #(.CELLS(34), .RW(19), .LANES(1), .SW(LSW)) u_lux_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .rem_i   (l_rem),
    .bits_i  (l_bits),
    .div_i   (a_den_q),
    .side_i  (l_side_in),
    .valid_o (l_valid),
    .quot_o  (l_quot),
    .side_o  (l_side)
  );

  logic        l_pos;
  logic [31:0] l_x, l_y;
  logic [33:0] l_s;
  logic [LUX_W-1:0] l_lux;

  assign {l_pos, l_x, l_y, l_s} = l_side;
  assign l_lux = !l_pos ? '0 :
                 (|l_quot[0][33:LUX_W]) ? LUX_MAX : l_quot[0][LUX_W-1:0];

  // ---------------- chromaticity divider (x and y share S) ----------------
  localparam int XSW = LUX_W + 1;

  logic               xy_valid;
  logic [1:0][33:0]   xy_rem;
  logic [1:0][16:0]   xy_bits, xy_quot;
  logic [XSW-1:0]     xy_side;

  // X <= S, so the first step starts from X / 2 and brings in its low bit
  assign xy_rem[0]  = {3'b000, l_x[31:1]};
  assign xy_rem[1]  = {3'b000, l_y[31:1]};
  assign xy_bits[0] = {l_x[0], 16'd0};
  assign xy_bits[1] = {l_y[0], 16'd0};

  rlce_div_chain #(.CELLS(17), .RW(34), .LANES(2), .SW(XSW)) u_xy_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (l_valid),
    .rem_i   (xy_rem),
    .bits_i  (xy_bits),
    .div_i   (l_s),
    .side_i  ({l_lux, (l_s == 34'd0)}),
    .valid_o (xy_valid),
    .quot_o  (xy_quot),
    .side_o  (xy_side)
  );

  // ---------------- stage C: n numerator and denominator ----------------
  logic signed [17:0] c_num_w, c_den_w;
  logic [17:0]        c_num_abs_w, c_den_abs_w;

  assign c_num_w     = $signed({1'b0, xy_quot[0]}) - X_OFFSET;
  assign c_den_w     = Y_OFFSET - $signed({1'b0, xy_quot[1]});
  assign c_num_abs_w = c_num_w[17] ? 18'(-c_num_w) : 18'(c_num_w);
  assign c_den_abs_w = c_den_w[17] ? 18'(-c_den_w) : 18'(c_den_w);

  logic             c_valid_q, c_neg_q, c_dzero_q, c_szero_q;
  logic [15:0]      c_num_q, c_den_q;
  logic [LUX_W-1:0] c_lux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= xy_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_num_q   <= c_num_abs_w[15:0];
      c_den_q   <= c_den_abs_w[15:0];
      c_neg_q   <= c_num_w[17] != c_den_w[17];
      c_dzero_q <= c_den_w == 18'sd0;
      {c_lux_q, c_szero_q} <= xy_side;
    end
  end

  // ---------------- n divider ----------------
  localparam int NSW = LUX_W + 4;

  logic             c_ovf;
  logic             n_valid;
  logic [0:0][15:0] n_rem;
  logic [0:0][22:0] n_bits, n_quot;
  logic [NSW-1:0]   n_side;

  // quotient reaches 2^23 when num >= 128 den: saturate then
  assign c_ovf     = {7'd0, c_num_q} >= {c_den_q, 7'd0};
  assign n_rem[0]  = {7'd0, c_num_q[15:7]};
  assign n_bits[0] = {c_num_q[6:0], 16'd0};

  rlce_div_chain #(.CELLS(23), .RW(16), .LANES(1), .SW(NSW)) u_n_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid_q),
    .rem_i   (n_rem),
    .bits_i  (n_bits),
    .div_i   (c_den_q),
    .side_i  ({c_lux_q, c_szero_q, c_dzero_q, c_ovf, c_neg_q}),
    .valid_o (n_valid),
    .quot_o  (n_quot),
    .side_o  (n_side)
  );

  logic [LUX_W-1:0] n_lux;
  logic             n_szero, n_dzero, n_ovf, n_neg;
  logic [22:0]      n_mag;

  assign {n_lux, n_szero, n_dzero, n_ovf, n_neg} = n_side;
  assign n_mag = (n_ovf || (n_quot[0] > N_LIMIT)) ? N_LIMIT : n_quot[0];

  // ---------------- cubic pipeline ----------------
  logic                     d_valid_q, e_valid_q, f_valid_q, g_valid_q, h_valid_q;
  logic signed [23:0]       d_n_q, e_n_q, f_n_q, g_n_q;
  logic signed [33:0]       e_a1_q;
  logic signed [41:0]       f_lo_q;
  logic signed [40:0]       f_hi_q;
  logic signed [40:0]       g_a2_q;
  logic signed [44:0]       h_lo_q, h_hi_q;
  logic signed [48:0]       i_a3_q;
  logic signed [55:0]       g_full_w;
  logic signed [63:0]       i_full_w;
  logic [LUX_W-1:0]         d_lux_q, e_lux_q, f_lux_q, g_lux_q, h_lux_q, i_lux_q;
  logic [1:0]               d_flg_q, e_flg_q, f_flg_q, g_flg_q, h_flg_q, i_flg_q;

  assign g_full_w = (56'(f_hi_q) <<< 17) + 56'(f_lo_q);
  assign i_full_w = (64'(h_hi_q) <<< 20) + 64'(h_lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
      i_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= n_valid;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      g_valid_q <= f_valid_q;
      h_valid_q <= g_valid_q;
      i_valid_q <= h_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_n_q   <= n_neg ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
      d_lux_q <= n_lux;
      d_flg_q <= {n_szero, n_dzero};

      e_a1_q  <= 34'(d_n_q) * C3_INT + C2_Q16;
      e_n_q   <= d_n_q;
      e_lux_q <= d_lux_q;
      e_flg_q <= d_flg_q;

      // split a1 into a signed high half and an unsigned low half
      f_lo_q  <= 42'($signed({1'b0, e_a1_q[16:0]})) * 42'(e_n_q);
      f_hi_q  <= 41'($signed(e_a1_q[33:17])) * 41'(e_n_q);
      f_n_q   <= e_n_q;
      f_lux_q <= e_lux_q;
      f_flg_q <= e_flg_q;

      g_a2_q  <= 41'(g_full_w >>> 16) + C1_Q16;
      g_n_q   <= f_n_q;
      g_lux_q <= f_lux_q;
      g_flg_q <= f_flg_q;

      h_lo_q  <= 45'($signed({1'b0, g_a2_q[19:0]})) * 45'(g_n_q);
      h_hi_q  <= 45'($signed(g_a2_q[40:20])) * 45'(g_n_q);
      h_lux_q <= g_lux_q;
      h_flg_q <= g_flg_q;

      i_a3_q  <= 49'(i_full_w >>> 16) + C0_Q16;
      i_lux_q <= h_lux_q;
      i_flg_q <= h_flg_q;
    end
  end

  // ---------------- output register ----------------
  logic [KELV_W-1:0] kelv_w;
  logic              sat_w;

  always_comb begin
    priority if (i_flg_q[1]) begin
      kelv_w = '0;
      sat_w  = 1'b0;
    end else if (i_flg_q[0]) begin
      kelv_w = KELV_MAX;
      sat_w  = 1'b1;
    end else if (i_a3_q[48]) begin
      kelv_w = '0;
      sat_w  = 1'b0;
    end else if (|i_a3_q[47:32]) begin
      kelv_w = KELV_MAX;
      sat_w  = 1'b1;
    end else begin
      kelv_w = i_a3_q[31:16];
      sat_w  = 1'b0;
    end
  end

  logic [LUX_W-1:0]  out_lux_q;
  logic [KELV_W-1:0] out_kelv_q;
  logic              out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= i_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_lux_q  <= i_lux_q;
      out_kelv_q <= kelv_w;
      out_sat_q  <= sat_w;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.lux_sixteenths = out_lux_q;
  assign out_o.cct_kelvin     = out_kelv_q;
  assign out_o.cct_saturated  = out_sat_q;

  // ---------------- assertions ----------------
  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.cct_saturated |-> out_o.cct_kelvin == KELV_MAX)
    else $error("saturation flag without full-scale temperature");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled while the output side can move");

  a_zero_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.cct_kelvin == '0 |-> !out_o.cct_saturated)
    else $error("zero temperature flagged as saturated");

endmodule

[src/rlce_div_cell.sv]
// One restoring-division step: shifts in a dividend bit, subtracts the divisor
// when it fits and appends the quotient bit. No package dependency.
module rlce_div_cell #(
  parameter int CELLS = 17,
  parameter int RW    = 34,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [LANES-1:0][RW-1:0]          rem_i,
  input  logic [LANES-1:0][CELLS-1:0]       bits_i,
  input  logic [LANES-1:0][CELLS-1:0]       quot_i,
  input  logic [RW-1:0]                     div_i,
  input  logic [SW-1:0]                     side_i,
  output logic                              valid_o,
  output logic [LANES-1:0][RW-1:0]          rem_o,
  output logic [LANES-1:0][CELLS-1:0]       bits_o,
  output logic [LANES-1:0][CELLS-1:0]       quot_o,
  output logic [RW-1:0]                     div_o,
  output logic [SW-1:0]                     side_o
);

  logic                        valid_q;
  logic [LANES-1:0][RW-1:0]    rem_d, rem_q;
  logic [LANES-1:0][CELLS-1:0] bits_d, bits_q;
  logic [LANES-1:0][CELLS-1:0] quot_d, quot_q;
  logic [RW-1:0]               div_q;
  logic [SW-1:0]               side_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [RW:0]   rem2;
    logic [RW+1:0] diff;
    logic          fits;
    assign rem2       = {rem_i[l], bits_i[l][CELLS-1]};
    assign diff       = {1'b0, rem2} - {2'b00, div_i};
    assign fits       = ~diff[RW+1];
    assign rem_d[l]   = fits ? diff[RW-1:0] : rem2[RW-1:0];
    assign bits_d[l]  = {bits_i[l][CELLS-2:0], 1'b0};
    assign quot_d[l]  = {quot_i[l][CELLS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      bits_q <= bits_d;
      quot_q <= quot_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign bits_o  = bits_q;
  assign quot_o  = quot_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

[src/rlce_div_chain.sv]
// Row of division cells, one quotient bit per cell, one cell per cycle while en_i is high.
// Depends on rlce_div_cell.
module rlce_div_chain #(
  parameter int CELLS = 17,
  parameter int RW    = 34,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][RW-1:0]    rem_i,
  input  logic [LANES-1:0][CELLS-1:0] bits_i,
  input  logic [RW-1:0]               div_i,
  input  logic [SW-1:0]               side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][CELLS-1:0] quot_o,
  output logic [SW-1:0]               side_o
);

  logic [CELLS:0]                          v_s;
  logic [CELLS:0][LANES-1:0][RW-1:0]       rem_s;
  logic [CELLS:0][LANES-1:0][CELLS-1:0]    bits_s;
  logic [CELLS:0][LANES-1:0][CELLS-1:0]    quot_s;
  logic [CELLS:0][RW-1:0]                  div_s;
  logic [CELLS:0][SW-1:0]                  side_s;

  assign v_s[0]    = valid_i;
  assign rem_s[0]  = rem_i;
  assign bits_s[0] = bits_i;
  assign quot_s[0] = '0;
  assign div_s[0]  = div_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    rlce_div_cell #(
      .CELLS(CELLS), .RW(RW), .LANES(LANES), .SW(SW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (v_s[k]),
      .rem_i   (rem_s[k]),
      .bits_i  (bits_s[k]),
      .quot_i  (quot_s[k]),
      .div_i   (div_s[k]),
      .side_i  (side_s[k]),
      .valid_o (v_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .bits_o  (bits_s[k+1]),
      .quot_o  (quot_s[k+1]),
      .div_o   (div_s[k+1]),
      .side_o  (side_s[k+1])
    );
  end

  assign valid_o = v_s[CELLS];
  assign quot_o  = quot_s[CELLS];
  assign side_o  = side_s[CELLS];

endmodule
